FILE: rtl/core/sparse_table_range_query_assert.svh
// ----------------------------------------------------------------------------
// Sparse table range query assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_QUERY_ASSERT_SVH
`define SPARSE_TABLE_RANGE_QUERY_ASSERT_SVH

// Condition holds at every clock edge
`define STRQ_ASSERT_HOLDS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define STRQ_ASSERT_IMPLIES(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define STRQ_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/strq_pkg.sv
// ----------------------------------------------------------------------------
// Sparse table range query package
// Table geometry, field widths, operation and combine codes, transaction types.
// ----------------------------------------------------------------------------
package strq_pkg;

    // Table geometry
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int VALUE_WIDTH  = 32;

    // Transaction field widths
    localparam int OP_W       = 2;
    localparam int IN_VALUE_W = 32;
    localparam int POS_W      = 10;
    localparam int ANSWER_W   = 32;
    localparam int MODE_W     = 2;

    // Derived widths
    localparam int IDX_W     = $clog2(MAX_ELEMENTS);
    localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int MEM_DEPTH = LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int LEN_W     = POS_W + 1;
    localparam int SPAN_W    = (IDX_W + 1 > LEVELS) ? IDX_W + 1 : LEVELS;

    // Register port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_COMBINE_MODE = 1'b0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Combine modes
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AND = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OR  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [IN_VALUE_W-1:0] value;
        logic [POS_W-1:0]      left;
        logic [POS_W-1:0]      right;
    } req_t;

    typedef struct packed {
        logic [ANSWER_W-1:0] answer;
        logic                error;
    } rsp_t;

endpackage

FILE: rtl/core/sparse_table_range_query.sv
// ----------------------------------------------------------------------------
// Sparse table range query: append at position pos writes table levels 0 through L, where
// L = min(floor(log2(pos + 1)), 10), one level per cycle.
// Query checks the range, reads two spans and combines them; clear, full append and code 3 go to the result.
// One transaction at a time; requests stall until the sequencer is back in idle after the result loads.
// Reset clears state, count, combine mode and result valid only; table memory is not swept.
// ----------------------------------------------------------------------------
`include "sparse_table_range_query_assert.svh"

module sparse_table_range_query (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  strq_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output strq_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [strq_pkg::PADDR_W-1:0]  paddr,
    input  logic [strq_pkg::PDATA_W-1:0]  pwdata,
    output logic [strq_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import strq_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_AP_START = 4'd1;
    localparam logic [3:0] S_AP_LOOP  = 4'd2;
    localparam logic [3:0] S_Q_CHECK  = 4'd3;
    localparam logic [3:0] S_Q_LVL    = 4'd4;
    localparam logic [3:0] S_Q_RD2    = 4'd5;
    localparam logic [3:0] S_Q_FIN    = 4'd6;
    localparam logic [3:0] S_OUT      = 4'd7;

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic                   out_valid_reg, out_valid_next;

    // Working payload
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [IDX_W-1:0]       start_reg, start_next;
    logic [LVL_W-1:0]       k_reg, k_next;
    logic [POS_W-1:0]       lo_reg, lo_next;
    logic [POS_W-1:0]       hi_reg, hi_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LVL_W-1:0]       lvl_reg, lvl_next;
    logic [IDX_W-1:0]       second_reg, second_next;
    logic [ANSWER_W-1:0]    res_answer_reg, res_answer_next;
    logic                   res_error_reg, res_error_next;
    rsp_t                   out_data_reg, out_data_next;

    // Table memory
    logic [VALUE_WIDTH-1:0] level_mem [MEM_DEPTH];
    logic [VALUE_WIDTH-1:0] mem_rdata_reg;
    logic                   mem_we, mem_re;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;

    // Shared datapath
    logic [SPAN_W-1:0]      span;
    logic [IDX_W-1:0]       start_minus;
    logic                   append_more;
    logic [VALUE_WIDTH-1:0] merged;
    logic [VALUE_WIDTH-1:0] level_wdata;
    logic [LVL_W-1:0]       q_lvl;
    logic [IDX_W-1:0]       q_second;
    logic                   cfg_write;

    function automatic logic [VALUE_WIDTH-1:0] merge_values(
        input logic [MODE_W-1:0]      mode,
        input logic [VALUE_WIDTH-1:0] a,
        input logic [VALUE_WIDTH-1:0] b
    );
        logic [VALUE_WIDTH-1:0] r;
        unique case (mode)
            MODE_MIN: r = (a < b) ? a : b;
            MODE_MAX: r = (a > b) ? a : b;
            MODE_AND: r = a & b;
            MODE_OR:  r = a | b;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] table_addr(
        input logic [LVL_W-1:0] lvl,
        input logic [IDX_W-1:0] idx
    );
        return ADDR_W'(lvl) * ADDR_W'(MAX_ELEMENTS) + ADDR_W'(idx);
    endfunction

    // Register port: always ready, one combine mode register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[PADDR_W-1:2] == REG_COMBINE_MODE);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_COMBINE_MODE) ? PDATA_W'(mode_reg)
                                                               : '0;

    // Handshake outputs
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // Append level step: span of the level just written, start of the next one
    assign span        = SPAN_W'(1) << k_reg;
    assign start_minus = IDX_W'(SPAN_W'(start_reg) - span);
    assign append_more = (int'(k_reg) + 1 < LEVELS) && (SPAN_W'(start_reg) >= span);
    assign merged      = merge_values(mode_reg, mem_rdata_reg, acc_reg);
    assign level_wdata = (state_reg == S_AP_START) ? value_reg : merged;

    // Query level: floor of log2 of range length, capped at the top level
    always_comb
    begin
        int lvl_int;
        lvl_int = 0;
        for (int i = 0; i < LEN_W; i++)
        begin
            if (len_reg[i])
            begin
                lvl_int = i;
            end
        end
        if (lvl_int > LEVELS - 1)
        begin
            lvl_int = LEVELS - 1;
        end
        q_lvl    = LVL_W'(lvl_int);
        q_second = IDX_W'(LEN_W'(hi_reg) + LEN_W'(1) - (LEN_W'(1) << lvl_int));
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        mode_next       = mode_reg;
        out_valid_next  = out_valid_reg;
        value_next      = value_reg;
        acc_next        = acc_reg;
        start_next      = start_reg;
        k_next          = k_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        len_next        = len_reg;
        lvl_next        = lvl_reg;
        second_next     = second_reg;
        res_answer_next = res_answer_reg;
        res_error_next  = res_error_reg;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        // Take a register write
        if (cfg_write)
        begin
            mode_next = pwdata[MODE_W-1:0];
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_answer_next = '0;
                    res_error_next  = 1'b0;
                    unique case (req.operation)
                        OP_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_ELEMENTS))
                            begin
                                res_error_next = 1'b1;
                                state_next     = S_OUT;
                            end
                            else
                            begin
                                value_next = VALUE_WIDTH'(req.value);
                                start_next = IDX_W'(count_reg);
                                k_next     = '0;
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_AP_START;
                            end
                        end
                        OP_QUERY:
                        begin
                            lo_next    = req.left;
                            hi_next    = req.right;
                            state_next = S_Q_CHECK;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            // Write one level entry ending at the new position, fetch the next partner
            S_AP_START, S_AP_LOOP:
            begin
                mem_we    = 1'b1;
                mem_waddr = table_addr(k_reg, start_reg);
                mem_wdata = level_wdata;
                acc_next  = level_wdata;
                if (append_more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = table_addr(k_reg, start_minus);
                    start_next = start_minus;
                    k_next     = k_reg + LVL_W'(1);
                    state_next = S_AP_LOOP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            // Check range against the stored count
            S_Q_CHECK:
            begin
                if ((lo_reg > hi_reg) || (int'(hi_reg) >= int'(count_reg)))
                begin
                    res_error_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    len_next   = LEN_W'(hi_reg) - LEN_W'(lo_reg) + LEN_W'(1);
                    state_next = S_Q_LVL;
                end
            end

            // Read the span starting at left
            S_Q_LVL:
            begin
                mem_re      = 1'b1;
                mem_raddr   = table_addr(q_lvl, IDX_W'(lo_reg));
                lvl_next    = q_lvl;
                second_next = q_second;
                state_next  = S_Q_RD2;
            end

            // Hold the first span, read the span ending at right
            S_Q_RD2:
            begin
                mem_re     = 1'b1;
                mem_raddr  = table_addr(lvl_reg, second_reg);
                acc_next   = mem_rdata_reg;
                state_next = S_Q_FIN;
            end

            // Combine both spans
            S_Q_FIN:
            begin
                res_answer_next = ANSWER_W'(merge_values(mode_reg, acc_reg, mem_rdata_reg));
                state_next      = S_OUT;
            end

            // Load the result register when it is free
            S_OUT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.answer = res_answer_reg;
                    out_data_next.error  = res_error_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= MODE_MIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        acc_reg        <= acc_next;
        start_reg      <= start_next;
        k_reg          <= k_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        len_reg        <= len_next;
        lvl_reg        <= lvl_next;
        second_reg     <= second_next;
        res_answer_reg <= res_answer_next;
        res_error_reg  <= res_error_next;
        out_data_reg   <= out_data_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= level_mem[mem_raddr];
        end
    end

    // Checks
    `STRQ_ASSERT_HOLDS(a_count_in_range, count_reg <= CNT_W'(MAX_ELEMENTS),
                       "count beyond capacity")
    `STRQ_ASSERT_IMPLIES(a_no_port_clash, mem_we && mem_re, mem_waddr != mem_raddr,
                         "read and write hit same entry")
    `STRQ_ASSERT_IMPLIES(a_level_in_range, state_reg == S_AP_LOOP,
                         (k_reg != LVL_W'(0)) && (int'(k_reg) < LEVELS),
                         "append level out of range")
    `STRQ_ASSERT_NEXT(a_clear_empties,
                      req_valid && !req_stall && req.operation == OP_CLEAR,
                      count_reg == '0, "clear left entries")
    `STRQ_ASSERT_IMPLIES(a_error_zero_answer, rsp_valid && rsp.error, rsp.answer == '0,
                         "error result with nonzero answer")

endmodule
